// File: rtl/core/sct_pkg.sv
`default_nettype none

package sct_pkg;

    localparam int unsigned TableDepthDefault = 64;

    // Fixed result field widths
    localparam int unsigned PosOutW = 7;

    localparam logic FUNC_COMMIT     = 1'b0;
    localparam logic FUNC_DISCONNECT = 1'b1;

    // Composite key, most significant part first, so a packed compare orders it
    typedef struct packed {
        logic [7:0]  conn_type;
        logic [15:0] own_port;
        logic [15:0] peer_port;
        logic [31:0] peer_addr;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic        connected;
        logic [63:0] last_active;
    } t_entry;

    // Per-operation command broadcast to every cell in the update cycle
    typedef struct packed {
        logic insert;
        logic hit;
        logic connected;
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/sct_cell.sv
`default_nettype none

module sct_cell
    import sct_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CNT_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_cmp_en,
    input  wire t_key             i_probe,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire t_cell_cmd        i_cmd,
    input  wire t_entry           i_new_entry,
    input  wire logic             i_prev_lt,
    input  wire t_entry           i_prev_entry,
    output logic                  o_lt,
    output logic                  o_eq,
    output logic                  o_boundary,
    output t_entry                o_entry
);

    t_entry r_entry;
    logic   r_lt;
    logic   r_eq;
    logic   w_valid;

    assign w_valid = CNT_W'(INDEX) < i_count;

    // Latch compare flags against the probe at accept
    always_ff @(posedge i_clk) begin
        if (i_cmp_en) begin
            r_lt <= w_valid && (r_entry.key < i_probe);
            r_eq <= w_valid && (r_entry.key == i_probe);
        end
    end

    // First cell at or above the probe key
    assign o_boundary = !r_lt && i_prev_lt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            if (o_boundary) begin
                r_entry <= i_new_entry;
            end else if (!i_prev_lt) begin
                r_entry <= i_prev_entry;
            end
        end else if (i_cmd.hit && r_eq) begin
            r_entry.connected   <= i_cmd.connected;
            r_entry.last_active <= i_new_entry.last_active;
        end
    end

    assign o_lt    = r_lt;
    assign o_eq    = r_eq;
    assign o_entry = r_entry;

endmodule

`default_nettype wire

// File: rtl/core/sct_pos_enc.sv
`default_nettype none

module sct_pos_enc
    import sct_pkg::*;
#(
    parameter int unsigned DEPTH = TableDepthDefault,
    parameter int unsigned IDX_W = $clog2(DEPTH)
) (
    input  wire logic [DEPTH-1:0] i_onehot,
    output logic                  o_any,
    output logic [IDX_W-1:0]      o_index
);

    always_comb begin
        o_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_onehot[i]) begin
                o_index = o_index | IDX_W'(i);
            end
        end
    end

    assign o_any = |i_onehot;

endmodule

`default_nettype wire

// File: rtl/core/sorted_connection_table.sv
// The cell row compares in the accept cycle and shifts or stamps in the following
// update cycle, at whose end the result of the item is registered; no new item
// enters then. A pending result that is not taken also holds off the next item.
// Reset (i_rst_n low, synchronous) empties the table and drops any pending result;
// entry storage is not cleared since slots at or above the count are never read.
`default_nettype none

module sorted_connection_table
    import sct_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_conn_type,
    input  wire logic [15:0] i_own_port,
    input  wire logic [15:0] i_peer_port,
    input  wire logic [31:0] i_peer_addr,
    input  wire logic [63:0] i_now_time,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_found,
    output logic [6:0]       o_position,
    output logic             o_table_full,
    output logic [6:0]       o_entries_used
);

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic             r_func;
    t_entry           r_new;

    logic             r_out_valid;
    logic             r_found;
    logic [CNT_W-1:0] r_pos;
    logic             r_full;
    logic [CNT_W-1:0] r_used;

    logic             w_accept;
    logic             w_cmp_en;
    logic             w_update;
    t_key             w_probe;
    t_cell_cmd        w_cmd;

    logic [TABLE_DEPTH-1:0] w_lt;
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [TABLE_DEPTH-1:0] w_boundary;
    t_entry                 w_entry [TABLE_DEPTH];

    logic             w_found;
    logic             w_full;
    logic             w_any_bound;
    logic [IDX_W-1:0] w_bound_idx;
    logic [CNT_W-1:0] w_pos;

    // ------------------------------------------------------------------
    // Control: idle (compare on accept), then the update cycle
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_update   = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = !r_out_valid || i_out_ready;
            ST_UPDATE: w_update   = 1'b1;
            default:   o_in_ready = 1'b0;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;
    assign w_cmp_en = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_probe = '{conn_type: i_conn_type,
                       own_port:  i_own_port,
                       peer_port: i_peer_port,
                       peer_addr: i_peer_addr};

    // Hold the item for the update cycle; a new key enters as connected
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func            <= i_func;
            r_new.key         <= w_probe;
            r_new.connected   <= 1'b1;
            r_new.last_active <= i_now_time;
        end
    end

    // ------------------------------------------------------------------
    // Cell row: each cell compares its entry; on insert, cells below the key hold,
    // the boundary takes the new entry, those above their lower neighbor's entry
    // ------------------------------------------------------------------
    assign w_found = |w_eq;
    assign w_full  = (r_count == CNT_W'(TABLE_DEPTH));

    assign w_cmd.insert    = w_update && (r_func == FUNC_COMMIT) && !w_found && !w_full;
    assign w_cmd.hit       = w_update && w_found;
    assign w_cmd.connected = (r_func == FUNC_COMMIT);

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            sct_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmp_en     (w_cmp_en),
                .i_probe      (w_probe),
                .i_count      (r_count),
                .i_cmd        (w_cmd),
                .i_new_entry  (r_new),
                .i_prev_lt    (1'b1),
                .i_prev_entry (r_new),
                .o_lt         (w_lt[g]),
                .o_eq         (w_eq[g]),
                .o_boundary   (w_boundary[g]),
                .o_entry      (w_entry[g])
            );
        end else begin : g_rest
            sct_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_cmp_en     (w_cmp_en),
                .i_probe      (w_probe),
                .i_count      (r_count),
                .i_cmd        (w_cmd),
                .i_new_entry  (r_new),
                .i_prev_lt    (w_lt[g-1]),
                .i_prev_entry (w_entry[g-1]),
                .o_lt         (w_lt[g]),
                .o_eq         (w_eq[g]),
                .o_boundary   (w_boundary[g]),
                .o_entry      (w_entry[g])
            );
        end
    end

    // Position: first cell not below the key; past the end when every slot is below
    sct_pos_enc #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_pos_enc (
        .i_onehot (w_boundary),
        .o_any    (w_any_bound),
        .o_index  (w_bound_idx)
    );

    assign w_pos = w_any_bound ? CNT_W'(w_bound_idx) : r_count;

    // ------------------------------------------------------------------
    // Entry count and result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cmd.insert) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_found <= w_found;
            r_pos   <= w_pos;
            r_full  <= (r_func == FUNC_COMMIT) && !w_found && w_full;
            r_used  <= w_cmd.insert ? r_count + CNT_W'(1) : r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_position     = PosOutW'(r_pos);
    assign o_table_full   = r_full;
    assign o_entries_used = PosOutW'(r_used);

endmodule

`default_nettype wire

// File: rtl/core/sct_checker.sv
`default_nettype none

module sct_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       o_in_ready,
    input  wire logic       o_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic       o_found,
    input  wire logic [6:0] o_position,
    input  wire logic       o_table_full
);

    // One item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted during update cycle");

    // An accept leads through the update state to a valid result
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> ##1 o_out_valid)
        else $error("result missing after accepted item");

    // A stalled result blocks the input side
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while result is stalled");

    // Full drop only for a new key
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_full) |-> !o_found)
        else $error("table_full reported for a present key");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_position)))
        else $error("stalled result changed");

endmodule

bind sorted_connection_table sct_checker u_sct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_found      (o_found),
    .o_position   (o_position),
    .o_table_full (o_table_full)
);

`default_nettype wire

// File: tb/sorted_connection_table_tb.sv
`timescale 1ns / 100ps

import sct_pkg::*;

// Tracks the table contents and checks each lookup result in order.
class sorted_table_checker;
    localparam int unsigned DEPTH = TableDepthDefault;

    typedef struct packed {
        logic       found;
        logic [6:0] position;
        logic       full;
        logic [6:0] used;
    } t_lookup;

    t_key        slot_key[DEPTH];
    logic        slot_connected[DEPTH];
    logic [63:0] slot_stamp[DEPTH];
    int unsigned used_count = 0;

    t_lookup pending_lookups[$];

    int errors        = 0;
    int n_inserts     = 0;
    int n_refreshes   = 0;
    int n_disconnects = 0;
    int n_misses      = 0;
    int n_drops       = 0;

    task report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    // Search, update the table copy, and queue the result this item must give.
    function void apply_lookup(input logic func, input t_key key, input logic [63:0] stamp);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int          i;
        bit          hit;
        t_lookup     res;
        lo  = 0;
        hi  = used_count;
        hit = 1'b0;
        while (lo < hi && !hit) begin
            mid = (lo + hi) / 2;
            if (key == slot_key[mid]) begin
                hit = 1'b1;
                lo  = mid;
            end else if (key < slot_key[mid]) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        res.full = 1'b0;
        if (hit) begin
            slot_connected[lo] = (func == FUNC_COMMIT);
            slot_stamp[lo]     = stamp;
            if (func == FUNC_COMMIT) n_refreshes++;
            else n_disconnects++;
        end else if (func == FUNC_COMMIT) begin
            if (used_count >= DEPTH) begin
                res.full = 1'b1;
                n_drops++;
            end else begin
                for (i = used_count; i > int'(lo); i--) begin
                    slot_key[i]       = slot_key[i-1];
                    slot_connected[i] = slot_connected[i-1];
                    slot_stamp[i]     = slot_stamp[i-1];
                end
                slot_key[lo]       = key;
                slot_connected[lo] = 1'b1;
                slot_stamp[lo]     = stamp;
                used_count++;
                n_inserts++;
            end
        end else begin
            n_misses++;
        end
        res.found    = hit;
        res.position = lo[6:0];
        res.used     = used_count[6:0];
        pending_lookups.push_back(res);
    endfunction

    task check_lookup(input logic found, input logic [6:0] position, input logic full,
                      input logic [6:0] used);
        t_lookup want;
        if (pending_lookups.size() == 0) begin
            report($sformatf("result with nothing pending: found=%b pos=%0d", found, position));
        end else begin
            want = pending_lookups.pop_front();
            if (found !== want.found)
                report($sformatf("found %b, want %b", found, want.found));
            if (position !== want.position)
                report($sformatf("position %0d, want %0d", position, want.position));
            if (full !== want.full)
                report($sformatf("table_full %b, want %b", full, want.full));
            if (used !== want.used)
                report($sformatf("entries_used %0d, want %0d", used, want.used));
        end
    endtask
endclass

module sorted_connection_table_tb;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        i_func         = FUNC_COMMIT;
    logic [7:0]  i_conn_type    = '0;
    logic [15:0] i_own_port     = '0;
    logic [15:0] i_peer_port    = '0;
    logic [31:0] i_peer_addr    = '0;
    logic [63:0] i_now_time     = '0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_found;
    logic [6:0]  o_position;
    logic        o_table_full;
    logic [6:0]  o_entries_used;

    // Idle rates in percent for the sender and the result taker.
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    sorted_table_checker board = new;

    sorted_connection_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_conn_type    (i_conn_type),
        .i_own_port     (i_own_port),
        .i_peer_port    (i_peer_port),
        .i_peer_addr    (i_peer_addr),
        .i_now_time     (i_now_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_position     (o_position),
        .o_table_full   (o_table_full),
        .o_entries_used (o_entries_used)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Take results: sample the handshake as it stood at the edge, then pick the
    // next ready value at random according to the current idle rate.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_lookup(o_found, o_position, o_table_full, o_entries_used);
        i_out_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one item and hold it until accepted. Valid stays high on return so
    // a following item can go out back to back; callers that pause must drop it.
    task automatic send_item(input logic func, input t_key key, input logic [63:0] stamp);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_conn_type <= key.conn_type;
        i_own_port  <= key.own_port;
        i_peer_port <= key.peer_port;
        i_peer_addr <= key.peer_addr;
        i_now_time  <= stamp;
        do @(posedge i_clk); while (!o_in_ready);
        board.apply_lookup(func, key, stamp);
    endtask

    // Drop valid and hold off until every queued result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending_lookups.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_stamp();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Build a key that is likely new: fully random, made of extreme parts, or a
    // near neighbor of a stored key that differs from it by one in a single part.
    function automatic t_key pick_new_key();
        t_key k;
        bit   up;
        up = $urandom_range(1);
        k  = t_key'(72'({$urandom, $urandom, $urandom}));
        case ($urandom_range(3))
            0: begin
                k.conn_type = $urandom_range(1) ? 8'hFF : 8'h00;
                k.own_port  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                k.peer_port = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                k.peer_addr = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            end
            1, 2: begin
                if (board.used_count > 0) begin
                    k = board.slot_key[$urandom_range(board.used_count - 1)];
                    case ($urandom_range(3))
                        0: k.conn_type = up ? k.conn_type + 8'd1 : k.conn_type - 8'd1;
                        1: k.own_port  = up ? k.own_port + 16'd1 : k.own_port - 16'd1;
                        2: k.peer_port = up ? k.peer_port + 16'd1 : k.peer_port - 16'd1;
                        default: k.peer_addr = up ? k.peer_addr + 32'd1 : k.peer_addr - 32'd1;
                    endcase
                end
            end
            default: ;
        endcase
        return k;
    endfunction

    // Mostly touch keys already stored; a fifth of items try a new key, so the
    // table fills gradually and the later part runs against a full table.
    task automatic random_item();
        t_key k;
        logic func;
        if (board.used_count > 0 && $urandom_range(99) < 80) begin
            k    = board.slot_key[$urandom_range(board.used_count - 1)];
            func = ($urandom_range(3) == 0) ? FUNC_DISCONNECT : FUNC_COMMIT;
        end else begin
            k    = pick_new_key();
            func = ($urandom_range(4) == 0) ? FUNC_DISCONNECT : FUNC_COMMIT;
        end
        send_item(func, k, pick_stamp());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table miss, extreme keys and stamps, refresh and
        // disconnect of present keys, and keys that differ in one part only.
        send_idle_pct = 19;
        take_idle_pct = 61;
        send_item(FUNC_DISCONNECT, t_key'{8'h00, 16'h0000, 16'h0000, 32'h0}, 64'd5);
        send_item(FUNC_COMMIT,     t_key'{8'h00, 16'h0000, 16'h0000, 32'h0}, 64'd0);
        send_item(FUNC_COMMIT,     t_key'{8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, '1);
        send_item(FUNC_COMMIT,     t_key'{8'h00, 16'h0000, 16'h0000, 32'h0}, 64'd7);
        send_item(FUNC_DISCONNECT, t_key'{8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 64'd8);
        send_item(FUNC_DISCONNECT, t_key'{8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 64'd9);
        send_item(FUNC_COMMIT,     t_key'{8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}, 64'd10);
        send_item(FUNC_DISCONNECT, t_key'{8'h80, 16'h8000, 16'h8000, 32'h8000_0000}, 64'd11);
        send_item(FUNC_COMMIT,     t_key'{8'h00, 16'h0000, 16'h0000, 32'h1}, 64'd12);
        send_item(FUNC_COMMIT,     t_key'{8'h00, 16'h0000, 16'h0001, 32'h0}, 64'd13);
        send_item(FUNC_COMMIT,     t_key'{8'h00, 16'h0001, 16'h0000, 32'h0}, 64'd14);
        send_item(FUNC_COMMIT,     t_key'{8'h01, 16'h0000, 16'h0000, 32'h0}, 64'd15);
        send_item(FUNC_COMMIT,     t_key'{8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFE}, 64'd16);
        send_item(FUNC_COMMIT,     t_key'{8'h00, 16'h0000, 16'h0000, 32'hFFFF_FFFF}, 64'd17);
        send_item(FUNC_DISCONNECT, t_key'{8'h00, 16'h0000, 16'h0000, 32'h1}, 64'd18);
        send_item(FUNC_COMMIT,     t_key'{8'h80, 16'h8000, 16'h8000, 32'h8000_0000}, '1);
        send_item(FUNC_DISCONNECT, t_key'{8'h00, 16'h0000, 16'h0000, 32'h2}, 64'd20);

        // Random: quicker sender with busy taker, then the reverse, then full speed.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 19; take_idle_pct = 61; end
                1: begin send_idle_pct = 61; take_idle_pct = 19; end
                default: begin send_idle_pct = 0; take_idle_pct = 0; end
            endcase
            for (int n = 0; n < 215; n++) begin
                random_item();
                if (phase == 0 && n == 100)
                    drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (board.pending_lookups.size() != 0)
            board.report($sformatf("%0d results never arrived", board.pending_lookups.size()));

        $display("Covered %0d inserts, %0d refreshes, %0d disconnects, %0d misses, %0d drops.",
                 board.n_inserts, board.n_refreshes, board.n_disconnects, board.n_misses,
                 board.n_drops);
        $display("Final table held %0d entries; %0d mismatches.", board.used_count, board.errors);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sorted_connection_table.f
rtl/core/sct_pkg.sv
rtl/core/sct_cell.sv
rtl/core/sct_pos_enc.sv
rtl/core/sorted_connection_table.sv
rtl/core/sct_checker.sv
tb/sorted_connection_table_tb.sv
